// ===== rtl/assert_macros.svh =====
// Assertion macros for RTL files that check their own logic.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tccs_pkg.sv =====
// Shared types and constants of the text console engine.
// Used by tccs_ctrl, tccs_dp and the top level; depends on nothing.
package tccs_pkg;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  NL_CODE    = 8'd10;
  localparam logic [7:0]  CR_CODE    = 8'd13;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_COPY,
    OP_BLANK,
    OP_PUT,
    OP_READ,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_func;      // func field on the input port
    logic scroll_pend;  // cursor row has run off the bottom
    logic copy_end;     // sweep counter at last row-copy step
    logic sweep_end;    // sweep counter at last cell
  } status_t;

endpackage

// ===== rtl/tccs_dp.sv =====
// Datapath of the text console engine: screen memory, cursor, sweep counter, result regs.
// Depends on tccs_pkg; driven by tccs_ctrl through cmd_t and status_t.
module tccs_dp import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_back_color,
  input  logic [3:0]  in_fore_color,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [15:0] out_cell_value,
  output logic        out_did_scroll
);

  localparam int N   = ROWS * COLUMNS;
  localparam int M   = (ROWS - 1) * COLUMNS;
  localparam int AW  = $clog2(N);
  localparam int RW  = $clog2(ROWS + 1);
  localparam int CLW = $clog2(COLUMNS);

  logic [15:0]    mem [N];
  logic [15:0]    rdata_r;

  logic [AW-1:0]  cnt_r;
  logic [RW-1:0]  cur_row_r;
  logic [CLW-1:0] cur_col_r;
  logic           scrolled_r;

  logic           func_r;
  logic [7:0]     char_r;
  logic [7:0]     attr_r;
  logic [4:0]     rd_row_r;
  logic [6:0]     rd_col_r;

  logic [4:0]     res_row_r;
  logic [6:0]     res_col_r;
  logic [15:0]    res_cell_r;
  logic           res_scroll_r;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [15:0]    wdata;
  logic           re;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  put_addr;
  logic [AW-1:0]  rd_addr;
  logic           in_range;
  logic           is_print;

  // Status back to the controller
  assign sts.in_func     = in_func;
  assign sts.scroll_pend = (cur_row_r >= RW'(ROWS));
  assign sts.copy_end    = (cnt_r == AW'(M));
  assign sts.sweep_end   = (cnt_r == AW'(N - 1));

  // Linear cell addresses
  assign put_addr = AW'(cur_row_r) * AW'(COLUMNS) + AW'(cur_col_r);
  assign rd_addr  = AW'(rd_row_r) * AW'(COLUMNS) + AW'(rd_col_r);
  assign in_range = (32'(rd_row_r) < ROWS) && (32'(rd_col_r) < COLUMNS);
  assign is_print = (char_r != NL_CODE) && (char_r != CR_CODE);

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = BLANK_CELL;
    re    = 1'b0;
    raddr = cnt_r + AW'(COLUMNS);
    case (cmd.op)
      OP_CLEAR, OP_BLANK: begin
        we = 1'b1;
      end
      OP_COPY: begin
        // read one row ahead, write the cell read last cycle
        re    = !sts.copy_end;
        we    = (cnt_r != '0);
        waddr = cnt_r - AW'(1);
        wdata = rdata_r;
      end
      OP_PUT: begin
        we    = is_print;
        waddr = put_addr;
        wdata = {attr_r, char_r};
      end
      OP_READ: begin
        re    = in_range;
        raddr = rd_addr;
      end
      default: begin
      end
    endcase
  end

  // Screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Cursor, sweep counter and scroll flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      scrolled_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          cnt_r      <= '0;
          scrolled_r <= 1'b0;
        end
        OP_CLEAR: begin
          cnt_r <= sts.sweep_end ? '0 : cnt_r + AW'(1);
        end
        OP_COPY: begin
          // hold at the last copy step so the blanking starts there
          if (!sts.copy_end) begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        OP_BLANK: begin
          cnt_r <= cnt_r + AW'(1);
          if (sts.sweep_end) begin
            cur_row_r  <= RW'(ROWS - 1);
            scrolled_r <= 1'b1;
          end
        end
        OP_PUT: begin
          if (char_r == NL_CODE) begin
            cur_col_r <= '0;
            cur_row_r <= cur_row_r + RW'(1);
          end else if (is_print) begin
            if (cur_col_r == CLW'(COLUMNS - 1)) begin
              cur_col_r <= '0;
              cur_row_r <= cur_row_r + RW'(1);
            end else begin
              cur_col_r <= cur_col_r + CLW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      func_r   <= in_func;
      char_r   <= in_char_code;
      attr_r   <= {in_back_color, in_fore_color};
      rd_row_r <= in_read_row;
      rd_col_r <= in_read_col;
    end
    if (cmd.op == OP_RESULT) begin
      res_row_r    <= 5'(cur_row_r);
      res_col_r    <= 7'(cur_col_r);
      res_cell_r   <= (func_r && in_range) ? rdata_r : 16'h0000;
      res_scroll_r <= scrolled_r;
    end
  end

  assign out_cursor_row = res_row_r;
  assign out_cursor_col = res_col_r;
  assign out_cell_value = res_cell_r;
  assign out_did_scroll = res_scroll_r;

endmodule

// ===== rtl/tccs_ctrl.sv =====
// Controller of the text console engine: sequences clear, scroll, put and read.
// Depends on tccs_pkg; drives tccs_dp through cmd_t and reads status_t.
module tccs_ctrl import tccs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t sts,
  output cmd_t    cmd,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COPY,
    S_BLANK,
    S_PUT,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.sweep_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (sts.in_func) begin
            state_nxt = S_READ;
          end else if (sts.scroll_pend) begin
            state_nxt = S_COPY;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_COPY: begin
        cmd.op = OP_COPY;
        if (sts.copy_end) begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.op = OP_BLANK;
        if (sts.sweep_end) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.op    = OP_PUT;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd.op        = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Text console engine: a ROWS x COLUMNS cell store with a cursor and scroll.
// An item is loaded, put or read, then its result is registered once the output register is
// free; only then is a new item taken. A put that performs a pending scroll first runs a
// row-copy sweep through the single-write, single-read screen memory, then blanks the last row.
// After reset a clearing pass writes blank to all ROWS*COLUMNS cells, one per cycle,
// and no item is taken until it ends.
`include "assert_macros.svh"

module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_back_color,
  input  logic [3:0]  in_fore_color,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic [15:0] out_cell_value,
  output logic        out_did_scroll
);

  cmd_t    cmd;
  status_t sts;

  // Sequencer
  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Memory, cursor and result
  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_back_color  (in_back_color),
    .in_fore_color  (in_fore_color),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_value (out_cell_value),
    .out_did_scroll (out_did_scroll)
  );

  // One item in flight: no transfer in right after another
  `AST_NXT(a_one_item, in_valid && in_ready, !in_ready)
  // Only a put scrolls, and a put returns an empty cell
  `AST_IMP(a_scroll_put, out_valid && out_did_scroll, out_cell_value == 16'h0000)
  // A scroll leaves the cursor in the last row or just past it
  `AST_IMP(a_scroll_row, out_valid && out_did_scroll && (ROWS < 31),
    (out_cursor_row == 5'(ROWS - 1)) || (out_cursor_row == 5'(ROWS)))
  // A transfer in is never taken while the clearing pass or a scroll runs
  `AST_IMP(a_busy, in_ready, cmd.op == OP_NONE || cmd.op == OP_LOAD)

endmodule
